// ===== design/tslu_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-level sorted ID lookup package
// Field widths, default table sizes and action codes shared by the lookup
// unit.
// ----------------------------------------------------------------------------
package tslu_pkg;

    // Default table geometry.
    localparam int SET_DEPTH_DEF = 256;
    localparam int MSG_DEPTH_DEF = 4096;
    localparam int ID_WIDTH_DEF  = 16;

    // Fixed field widths of the input and result beats.
    localparam int W_ACTION    = 2;
    localparam int W_SLOT      = 12;
    localparam int W_ID_PORT   = 16;
    localparam int W_FIRST     = 12;
    localparam int W_COUNT     = 13;
    localparam int W_OFFSET    = 24;
    localparam int W_SET_COUNT = 9;

    // Width of the search window counters (lo, n and midpoint m).
    localparam int W_WIN = 13;

    // Action codes.
    localparam logic [W_ACTION-1:0] ACT_LOAD_SET = 2'd0;
    localparam logic [W_ACTION-1:0] ACT_LOAD_MSG = 2'd1;
    localparam logic [W_ACTION-1:0] ACT_LOOKUP   = 2'd2;

endpackage

// ===== design/two_level_sorted_id_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// Two-level sorted ID lookup unit
// A lookup passes through an accept step in idle, the set-table probes (at most
// floor(log2(set count))+1), a slice setup step, the message probes (at most
// floor(log2(slice))+1) and a result step that waits for a free output
// register; each table RAM has a single read port, so probes go one at a time.
// Loads write the table from the idle state. Reset clears control state and
// set_count; the tables are undefined until loaded and get no clearing pass.
// ----------------------------------------------------------------------------
module two_level_sorted_id_lookup_unit #(
    parameter int SET_DEPTH = tslu_pkg::SET_DEPTH_DEF,
    parameter int MSG_DEPTH = tslu_pkg::MSG_DEPTH_DEF,
    parameter int ID_WIDTH  = tslu_pkg::ID_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tslu_pkg::W_SET_COUNT-1:0]    i_cfg_set_count,
    // Input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [tslu_pkg::W_ACTION-1:0]       i_action,
    input  logic [tslu_pkg::W_SLOT-1:0]         i_slot,
    input  logic [tslu_pkg::W_ID_PORT-1:0]      i_set_number,
    input  logic [tslu_pkg::W_ID_PORT-1:0]      i_msg_number,
    input  logic [tslu_pkg::W_FIRST-1:0]        i_first_msg,
    input  logic [tslu_pkg::W_COUNT-1:0]        i_msg_count,
    input  logic [tslu_pkg::W_OFFSET-1:0]       i_text_offset_in,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [tslu_pkg::W_OFFSET-1:0]       o_text_offset
);

    import tslu_pkg::*;

    localparam int SA = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int MA = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
    localparam int SW = ID_WIDTH + W_FIRST + W_COUNT;
    localparam int MW = ID_WIDTH + W_OFFSET;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET_SRCH,
        S_MSG_START,
        S_MSG_SRCH,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [W_SET_COUNT-1:0]  r_set_count;
    logic [W_WIN-1:0]        r_lo, n_lo;
    logic [W_WIN-1:0]        r_n, n_n;
    logic [W_WIN-1:0]        r_m, n_m;
    logic [ID_WIDTH-1:0]     r_sid, n_sid;
    logic [ID_WIDTH-1:0]     r_mid_id, n_mid_id;
    logic [W_FIRST-1:0]      r_first, n_first;
    logic                    r_res_found, n_res_found;
    logic [W_OFFSET-1:0]     r_res_off, n_res_off;
    logic                    r_out_valid, n_out_valid;
    logic                    r_found, n_found;
    logic [W_OFFSET-1:0]     r_text_offset, n_text_offset;

    // RAM ports.
    logic          set_we, msg_we;
    logic [SA-1:0] set_waddr, set_raddr;
    logic [MA-1:0] msg_waddr, msg_raddr;
    logic [SW-1:0] set_wdata, set_rdata;
    logic [MW-1:0] msg_wdata, msg_rdata;

    // Fields of the words read back.
    logic [ID_WIDTH-1:0] set_rd_id, msg_rd_id;
    logic [W_FIRST-1:0]  set_rd_first;
    logic [W_COUNT-1:0]  set_rd_count;
    logic [W_OFFSET-1:0] msg_rd_off;

    // Search step helpers.
    logic [ID_WIDTH-1:0] key, probe_id;
    logic                key_eq, key_gt;
    logic [W_WIN-1:0]    step_lo, step_n, step_m;
    logic [31:0]         n0_set, slice_lim, slice_cnt;

    assign set_rd_id    = set_rdata[SW-1 -: ID_WIDTH];
    assign set_rd_first = set_rdata[W_COUNT +: W_FIRST];
    assign set_rd_count = set_rdata[W_COUNT-1:0];
    assign msg_rd_id    = msg_rdata[MW-1 -: ID_WIDTH];
    assign msg_rd_off   = msg_rdata[W_OFFSET-1:0];

    assign set_waddr = SA'(i_slot);
    assign msg_waddr = MA'(i_slot);
    assign set_wdata = {ID_WIDTH'(i_set_number), i_first_msg, i_msg_count};
    assign msg_wdata = {ID_WIDTH'(i_msg_number), i_text_offset_in};

    // One probe step: compare the key with the word read back and narrow the
    // window, then pick the next midpoint.
    always_comb begin
        key      = (r_state == S_MSG_SRCH) ? r_mid_id : r_sid;
        probe_id = (r_state == S_MSG_SRCH) ? msg_rd_id : set_rd_id;
        key_eq   = (key == probe_id);
        key_gt   = (key > probe_id);
        if (key_gt) begin
            step_lo = r_m + W_WIN'(1);
            step_n  = r_n - (r_n >> 1) - W_WIN'(1);
        end else begin
            step_lo = r_lo;
            step_n  = r_n >> 1;
        end
        step_m = step_lo + (step_n >> 1);
    end

    // Window sizes at the start of each search level.
    always_comb begin
        n0_set = (32'(r_set_count) > SET_DEPTH) ? SET_DEPTH : 32'(r_set_count);
        slice_lim = MSG_DEPTH - 32'(r_first);
        if (32'(r_first) >= MSG_DEPTH) begin
            slice_cnt = '0;
        end else if (32'(r_n) > slice_lim) begin
            slice_cnt = slice_lim;
        end else begin
            slice_cnt = 32'(r_n);
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state       = r_state;
        n_lo          = r_lo;
        n_n           = r_n;
        n_m           = r_m;
        n_sid         = r_sid;
        n_mid_id      = r_mid_id;
        n_first       = r_first;
        n_res_found   = r_res_found;
        n_res_off     = r_res_off;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_found       = r_found;
        n_text_offset = r_text_offset;
        set_we        = 1'b0;
        msg_we        = 1'b0;
        set_raddr     = SA'(r_m);
        msg_raddr     = MA'(32'(r_first) + 32'(r_m));

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_action)
                        ACT_LOAD_SET: begin
                            set_we = (32'(i_slot) < SET_DEPTH);
                        end
                        ACT_LOAD_MSG: begin
                            msg_we = (32'(i_slot) < MSG_DEPTH);
                        end
                        ACT_LOOKUP: begin
                            n_sid       = ID_WIDTH'(i_set_number);
                            n_mid_id    = ID_WIDTH'(i_msg_number);
                            n_lo        = '0;
                            n_n         = W_WIN'(n0_set);
                            n_m         = W_WIN'(n0_set) >> 1;
                            set_raddr   = SA'(W_WIN'(n0_set) >> 1);
                            n_res_found = 1'b0;
                            n_res_off   = '0;
                            n_state     = (n0_set == 32'd0) ? S_DONE : S_SET_SRCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SET_SRCH: begin
                if (key_eq) begin
                    n_first = set_rd_first;
                    n_n     = set_rd_count;
                    n_state = S_MSG_START;
                end else if (step_n == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_lo      = step_lo;
                    n_n       = step_n;
                    n_m       = step_m;
                    set_raddr = SA'(step_m);
                end
            end
            S_MSG_START: begin
                n_lo      = '0;
                n_n       = W_WIN'(slice_cnt);
                n_m       = W_WIN'(slice_cnt) >> 1;
                msg_raddr = MA'(32'(r_first) + 32'(W_WIN'(slice_cnt) >> 1));
                n_state   = (slice_cnt == 32'd0) ? S_DONE : S_MSG_SRCH;
            end
            S_MSG_SRCH: begin
                if (key_eq) begin
                    n_res_found = 1'b1;
                    n_res_off   = msg_rd_off;
                    n_state     = S_DONE;
                end else if (step_n == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_lo      = step_lo;
                    n_n       = step_n;
                    n_m       = step_m;
                    msg_raddr = MA'(32'(r_first) + 32'(step_m));
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_found       = r_res_found;
                    n_text_offset = r_res_off;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, configuration register and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_set_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_set_count <= i_cfg_set_count;
            end
        end
        r_lo          <= n_lo;
        r_n           <= n_n;
        r_m           <= n_m;
        r_sid         <= n_sid;
        r_mid_id      <= n_mid_id;
        r_first       <= n_first;
        r_res_found   <= n_res_found;
        r_res_off     <= n_res_off;
        r_found       <= n_found;
        r_text_offset <= n_text_offset;
    end

    // Set table: {set number, first message slot, message count}.
    tslu_ram #(
        .WIDTH (SW),
        .DEPTH (SET_DEPTH)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (set_we),
        .i_waddr (set_waddr),
        .i_wdata (set_wdata),
        .i_raddr (set_raddr),
        .o_rdata (set_rdata)
    );

    // Message table: {message number, text offset}.
    tslu_ram #(
        .WIDTH (MW),
        .DEPTH (MSG_DEPTH)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (msg_we),
        .i_waddr (msg_waddr),
        .i_wdata (msg_wdata),
        .i_raddr (msg_raddr),
        .o_rdata (msg_rdata)
    );

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_text_offset = r_text_offset;

endmodule

// ===== design/tslu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tslu_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
